// ===== hw/rtl/nfps_pkg.sv =====
// ----------------------------------------------------------------------------
// nfps_pkg - shared types and constants for the NTT-friendly prime search
// Field widths, the register reset value and the interface structs that
// pass through the block's ports and between the sequencer and the shared divider.
// ----------------------------------------------------------------------------
package nfps_pkg;

  localparam int FIELD_W   = 32;  // lower bound and modulus
  localparam int LIMIT_W   = 20;  // search limit and multiplier
  localparam int PRIME_W   = 53;  // reported prime
  localparam int CAND_W    = 52;  // every tested candidate is below 2^52
  localparam int ROOT_W    = 27;  // trial divisor, just above sqrt(2^52)
  localparam int DSQ_W     = 54;  // square of the trial divisor
  localparam int DIV_STEPS = CAND_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1000000);
  localparam logic [ROOT_W-1:0]  D_FIRST     = ROOT_W'(5);
  localparam logic [ROOT_W-1:0]  D_STEP      = ROOT_W'(6);

  typedef struct packed {
    logic [FIELD_W-1:0] lower_bound;
    logic [FIELD_W-1:0] step_modulus;
  } in_t;

  typedef struct packed {
    logic [PRIME_W-1:0] prime_value;
    logic               found;
  } out_t;

  typedef struct packed {
    logic               valid;
    logic [CAND_W-1:0]  dividend;
    logic [FIELD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [CAND_W-1:0]  quot;
    logic [FIELD_W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== hw/rtl/nfps_div.sv =====
// ----------------------------------------------------------------------------
// nfps_div - shared iterative divider
// Restoring division, one quotient bit per cycle, giving quotient and
// remainder of a 52-bit dividend by a non-zero 32-bit divisor.
// ----------------------------------------------------------------------------
module nfps_div (
  input  logic              clk,
  input  logic              rst_n,
  input  nfps_pkg::div_req_t req,
  output nfps_pkg::div_rsp_t rsp
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [nfps_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [nfps_pkg::CAND_W-1:0]   quo_r, quo_nxt;
  logic [nfps_pkg::FIELD_W-1:0]  rem_r, rem_nxt;
  logic [nfps_pkg::FIELD_W-1:0]  dvs_r, dvs_nxt;
  logic [nfps_pkg::FIELD_W:0]    rem_sh;
  logic [nfps_pkg::FIELD_W:0]    diff;
  logic                          geq;

  always_comb begin
    rem_sh = {rem_r, quo_r[nfps_pkg::CAND_W-1]};
    diff   = rem_sh - {1'b0, dvs_r};
    geq    = (rem_sh >= {1'b0, dvs_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (busy_r) begin
      rem_nxt = geq ? diff[nfps_pkg::FIELD_W-1:0] : rem_sh[nfps_pkg::FIELD_W-1:0];
      quo_nxt = {quo_r[nfps_pkg::CAND_W-2:0], geq};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.valid) begin
      busy_nxt = 1'b1;
      cnt_nxt  = nfps_pkg::CNT_W'(nfps_pkg::DIV_STEPS - 1);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== hw/rtl/ntt_friendly_prime_search.sv =====
// ----------------------------------------------------------------------------
// ntt_friendly_prime_search - smallest prime p > bound with p = 1 mod modulus
// Sequencer around one shared divider: start-point division, a digit-sum
// test for three, then trial division of each candidate 1 + modulus * t by
// 6k-1 and 6k+1.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the search ends (a zero modulus never raises it), and the result
// appears on out_data for exactly one cycle with out_valid high. The receiver
// cannot stall, so the result must be captured in that cycle. Every division
// in the block runs through one restoring divider at one bit per cycle. The
// start point costs one such division. After it an even candidate is
// rejected in ST_TEST, and a multiple of three in ST_MOD3, where it is caught
// by a sum of its base-four digits rather than by the divider; any other
// candidate takes two divisions for each trial pair d, d + 2 with d * d <= p
// (about sqrt(p) / 6 pairs), and fewer when a divisor is found early. The
// total therefore depends heavily on the data, as the number of trial pairs
// grows with the square root of the prime. A zero modulus gives its result
// (nothing found) in the cycle after start; a starting multiplier already at
// or above the search limit gives it after the start-point division alone.
// The search limit register is written through cfg_valid/cfg_ready and is
// only accepted while the block is idle and start is low; its reset value
// is 1000000.
// ----------------------------------------------------------------------------
module ntt_friendly_prime_search (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  nfps_pkg::in_t                 in_data,
  output logic                          out_valid,
  output nfps_pkg::out_t                out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nfps_pkg::LIMIT_W-1:0]  cfg_data
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DIV0  = 4'd1;  // waiting for bound / modulus
  localparam logic [3:0] ST_TEST  = 4'd2;  // quick checks on a new candidate
  localparam logic [3:0] ST_MOD3  = 4'd3;  // residue of p modulo three
  localparam logic [3:0] ST_CHKD  = 4'd4;  // compare divisor square with p
  localparam logic [3:0] ST_DIVD  = 4'd5;  // waiting for remainder by d
  localparam logic [3:0] ST_DIVD2 = 4'd6;  // waiting for remainder by d + 2

  localparam int FW = nfps_pkg::FIELD_W;
  localparam int LW = nfps_pkg::LIMIT_W;
  localparam int CW = nfps_pkg::CAND_W;
  localparam int RW = nfps_pkg::ROOT_W;
  localparam int SW = nfps_pkg::DSQ_W;

  logic [3:0]     state_r, state_nxt;
  logic [LW-1:0]  limit_r;
  logic [FW-1:0]  lb_r, lb_nxt;
  logic [FW-1:0]  m_r, m_nxt;
  logic [LW-1:0]  t_r, t_nxt;
  logic [CW-1:0]  p_r, p_nxt;
  logic [RW-1:0]  d_r, d_nxt;
  logic [SW-1:0]  dsq_r, dsq_nxt;
  logic [6:0]     dsum_r, dsum_nxt;
  logic           out_valid_r;
  nfps_pkg::out_t out_data_r;

  nfps_pkg::div_req_t div_req;
  nfps_pkg::div_rsp_t div_rsp;

  logic           fin_valid;
  logic           fin_found;
  logic           acc;
  logic           rej;
  logic           rem_zero;
  logic [FW:0]    t0;
  logic [FW+1:0]  mt0;
  logic [LW:0]    t_inc;
  logic [6:0]     dsum;
  logic [3:0]     fold1;
  logic [2:0]     fold2;
  logic           mod3_zero;

  nfps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Start point from q = lb / m, r = lb % m: t0 = q + (r != 0), at least 1.
  // m * t0 is then lb - r, plus m when r is non-zero, or just m when the
  // bound is zero, so no multiplier is needed.
  always_comb begin
    rem_zero = (div_rsp.rem == '0);
    t0       = div_rsp.quot[FW:0] + {{FW{1'b0}}, !rem_zero};
    mt0      = {2'b00, lb_r} - {2'b00, div_rsp.rem}
             + (rem_zero ? '0 : {2'b00, m_r});
    if (lb_r == '0) begin
      t0  = {{FW{1'b0}}, 1'b1};
      mt0 = {2'b00, m_r};
    end
    t_inc = {1'b0, t_r} + 1'b1;
  end

  // Since four is one modulo three, the sum of the base-four digits of p
  // keeps its residue. The sum (at most 78) is registered, then folded the
  // same way twice more, leaving a value of at most five.
  always_comb begin
    dsum = '0;
    for (int k = 0; k < CW / 2; k++) begin
      dsum = dsum + {5'b00000, p_r[2*k +: 2]};
    end
    fold1 = {2'b00, dsum_r[1:0]} + {2'b00, dsum_r[3:2]}
          + {2'b00, dsum_r[5:4]} + {3'b000, dsum_r[6]};
    fold2 = {1'b0, fold1[1:0]} + {1'b0, fold1[3:2]};
    mod3_zero = (fold2 == 3'd0) || (fold2 == 3'd3);
  end

  always_comb begin
    state_nxt = state_r;
    lb_nxt    = lb_r;
    m_nxt     = m_r;
    t_nxt     = t_r;
    p_nxt     = p_r;
    d_nxt     = d_r;
    dsq_nxt   = dsq_r;
    dsum_nxt  = dsum_r;
    fin_valid = 1'b0;
    fin_found = 1'b0;
    acc       = 1'b0;
    rej       = 1'b0;
    div_req   = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          lb_nxt = in_data.lower_bound;
          m_nxt  = in_data.step_modulus;
          if (in_data.step_modulus == '0) begin
            // Every candidate would be one, which is never prime.
            fin_valid = 1'b1;
          end else begin
            div_req.valid    = 1'b1;
            div_req.dividend = {{(CW-FW){1'b0}}, in_data.lower_bound};
            div_req.divisor  = in_data.step_modulus;
            state_nxt        = ST_DIV0;
          end
        end
      end
      ST_DIV0: begin
        if (div_rsp.done) begin
          if (t0 >= {{(FW+1-LW){1'b0}}, limit_r}) begin
            fin_valid = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            t_nxt     = t0[LW-1:0];
            p_nxt     = CW'(mt0) + 1'b1;
            state_nxt = ST_TEST;
          end
        end
      end
      ST_TEST: begin
        if (p_r < CW'(2)) begin
          rej = 1'b1;
        end else if (p_r < CW'(4)) begin
          acc = 1'b1;
        end else if (!p_r[0]) begin
          rej = 1'b1;
        end else begin
          dsum_nxt  = dsum;
          state_nxt = ST_MOD3;
        end
      end
      ST_MOD3: begin
        if (mod3_zero) begin
          rej = 1'b1;
        end else begin
          d_nxt     = nfps_pkg::D_FIRST;
          dsq_nxt   = SW'(nfps_pkg::D_FIRST) * SW'(nfps_pkg::D_FIRST);
          state_nxt = ST_CHKD;
        end
      end
      ST_CHKD: begin
        if (dsq_r > {{(SW-CW){1'b0}}, p_r}) begin
          acc = 1'b1;
        end else begin
          div_req.valid    = 1'b1;
          div_req.dividend = p_r;
          div_req.divisor  = {{(FW-RW){1'b0}}, d_r};
          state_nxt        = ST_DIVD;
        end
      end
      ST_DIVD: begin
        if (div_rsp.done) begin
          if (rem_zero) begin
            rej = 1'b1;
          end else begin
            div_req.valid    = 1'b1;
            div_req.dividend = p_r;
            div_req.divisor  = {{(FW-RW){1'b0}}, d_r + RW'(2)};
            state_nxt        = ST_DIVD2;
          end
        end
      end
      ST_DIVD2: begin
        if (div_rsp.done) begin
          if (rem_zero) begin
            rej = 1'b1;
          end else begin
            // (d + 6)^2 = d^2 + 12 d + 36
            dsq_nxt   = dsq_r + ({{(SW-RW){1'b0}}, d_r} << 3)
                      + ({{(SW-RW){1'b0}}, d_r} << 2) + SW'(36);
            d_nxt     = d_r + nfps_pkg::D_STEP;
            state_nxt = ST_CHKD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (acc) begin
      fin_valid = 1'b1;
      fin_found = 1'b1;
      state_nxt = ST_IDLE;
    end else if (rej) begin
      if (t_inc >= {1'b0, limit_r}) begin
        fin_valid = 1'b1;
        state_nxt = ST_IDLE;
      end else begin
        t_nxt     = t_inc[LW-1:0];
        p_nxt     = p_r + {{(CW-FW){1'b0}}, m_r};
        state_nxt = ST_TEST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      limit_r     <= nfps_pkg::LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= fin_valid;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    lb_r   <= lb_nxt;
    m_r    <= m_nxt;
    t_r    <= t_nxt;
    p_r    <= p_nxt;
    d_r    <= d_nxt;
    dsq_r  <= dsq_nxt;
    dsum_r <= dsum_nxt;
    if (fin_valid) begin
      out_data_r.found       <= fin_found;
      out_data_r.prime_value <= fin_found ? {1'b0, p_r} : '0;
    end
  end

  // A new limit is never taken in the same cycle as an item, so every item
  // runs under the limit that was in force when it was accepted.
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = !busy && !start;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_zero_when_missing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.prime_value == '0)
    else $error("prime_value not zero for a failed search");

  a_zero_modulus: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.step_modulus == '0 |=> out_valid && !out_data.found)
    else $error("zero modulus did not give an immediate empty result");

  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("search ended without a result");

  a_t_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_TEST |-> t_r < limit_r)
    else $error("candidate multiplier reached the search limit");
`endif

endmodule

// ===== sim/nfps_checker.sv =====
// ----------------------------------------------------------------------------
// nfps_checker - result checker for the NTT-friendly prime search
// Watches the request, result and search-limit channels, works out the
// expected prime for every accepted request and compares it with the result.
// ----------------------------------------------------------------------------
module nfps_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  nfps_pkg::in_t                in_data,
  input  logic                         out_valid,
  input  nfps_pkg::out_t               out_data,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [nfps_pkg::LIMIT_W-1:0] cfg_data,
  output int                           errors,
  output int                           pending,
  output int                           primes_found
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [nfps_pkg::LIMIT_W-1:0] limit_copy;
  nfps_pkg::out_t               prime_queue[$];

  // Trial division by 2, 3 and then 6k-1, 6k+1 up to the square root.
  function automatic bit trial_prime(longint unsigned n);
    longint unsigned d;
    if (n < 2) return 1'b0;
    if (n < 4) return 1'b1;
    if ((n % 2) == 0 || (n % 3) == 0) return 1'b0;
    d = 5;
    while (d * d <= n) begin
      if ((n % d) == 0 || (n % (d + 2)) == 0) return 1'b0;
      d += 6;
    end
    return 1'b1;
  endfunction

  function automatic nfps_pkg::out_t search_prime(nfps_pkg::in_t item,
                                                  logic [nfps_pkg::LIMIT_W-1:0] limit);
    longint unsigned bound;
    longint unsigned modulus;
    longint unsigned mult;
    longint unsigned cand;
    nfps_pkg::out_t  res;
    res     = '0;
    bound   = item.lower_bound;
    modulus = item.step_modulus;
    if (modulus != 0) begin
      mult = (bound + modulus - 1) / modulus;
      if (mult < 1) mult = 1;
      while (mult < limit) begin
        cand = 1 + modulus * mult;
        if (trial_prime(cand)) begin
          res.prime_value = cand[nfps_pkg::PRIME_W-1:0];
          res.found       = 1'b1;
          break;
        end
        mult++;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    nfps_pkg::out_t want;
    if (!rst_n) begin
      limit_copy = nfps_pkg::LIMIT_RESET;
      prime_queue.delete();
      errors       = 0;
      pending      = 0;
      primes_found = 0;
    end else begin
      if (out_valid) begin
        if (prime_queue.size() == 0) begin
          $display("%0t: result with nothing expected: prime_value=%0d found=%0b",
                   $time, out_data.prime_value, out_data.found);
          errors++;
        end else begin
          want = prime_queue.pop_front();
          if (out_data.prime_value !== want.prime_value ||
              out_data.found !== want.found) begin
            errors++;
            if (out_data.prime_value !== want.prime_value)
              $display("%0t: prime_value expected %0d, got %0d",
                       $time, want.prime_value, out_data.prime_value);
            if (out_data.found !== want.found)
              $display("%0t: found expected %0b, got %0b",
                       $time, want.found, out_data.found);
          end
          if (want.found) primes_found++;
        end
      end
      if (start && !busy) begin
        prime_queue.insert(prime_queue.size(), search_prime(in_data, limit_copy));
      end
      if (cfg_valid && cfg_ready) limit_copy = cfg_data;
      pending = prime_queue.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - testbench for the NTT-friendly prime search
// Sends directed and random search requests in bursts under several search
// limits, while a separate checker predicts every result and compares it.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // The slowest search in this run tests a handful of candidates near 2^20,
  // so the limit below leaves a wide margin.
  localparam int MAX_CYCLES   = 20_000_000;
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 60;
  localparam int NUM_PHASES   = 7;
  localparam logic [nfps_pkg::LIMIT_W-1:0] LIMIT_MAX = '1;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  nfps_pkg::in_t                in_data;
  logic                         out_valid;
  nfps_pkg::out_t               out_data;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [nfps_pkg::LIMIT_W-1:0] cfg_data;

  int errors;
  int pending;
  int primes_found;
  int cycle_count = 0;
  int items_sent  = 0;
  int limit_writes = 0;
  int burst_left  = 0;
  bit start_high  = 1'b0;

  always #5 clk = ~clk;

  ntt_friendly_prime_search u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  nfps_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .pending      (pending),
    .primes_found (primes_found)
  );

  // Watchdog: a hung search or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending);
      $display("ntt_friendly_prime_search: mismatch");
      $finish;
    end
  end

  // Drops start once, at the current falling edge, if it is still up. The
  // flag keeps start from receiving two assignments in one time step.
  task automatic lower_start();
    if (start_high) begin
      start <= 1'b0;
      start_high = 1'b0;
    end
  endtask

  // Called at a falling edge. The item is offered until the block takes it,
  // i.e. until a rising edge at which busy is low. Items go out back to back
  // within a burst; when a burst runs out start drops for a random gap.
  task automatic send_item(input logic [nfps_pkg::FIELD_W-1:0] bound,
                           input logic [nfps_pkg::FIELD_W-1:0] modulus);
    start   <= 1'b1;
    start_high = 1'b1;
    in_data <= '{lower_bound: bound, step_modulus: modulus};
    do @(posedge clk); while (busy);
    @(negedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      lower_start();
      repeat ($urandom_range(1, 40)) @(negedge clk);
      burst_left = $urandom_range(0, 6);
    end
  endtask

  // The limit may only change while the block is idle, so every outstanding
  // result is collected first and the block is given a few quiet cycles.
  task automatic write_limit(input logic [nfps_pkg::LIMIT_W-1:0] value);
    lower_start();
    while (pending != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    limit_writes++;
  endtask

  // Random request shaped to keep each search cheap. With a limit of one or
  // less no candidate is ever tested, so the full 32-bit ranges are safe and
  // this is where the upper bits of both fields get exercised. Otherwise most
  // requests are small searches (an even modulus more often, as that gives
  // odd candidates), with zero-modulus requests and requests whose starting
  // multiplier already lies beyond any limit mixed in.
  task automatic send_random(input logic [nfps_pkg::LIMIT_W-1:0] limit);
    logic [nfps_pkg::FIELD_W-1:0] bound;
    logic [nfps_pkg::FIELD_W-1:0] modulus;
    int                           kind;
    kind = $urandom_range(0, 9);
    if (limit <= 1) begin
      bound   = $urandom;
      modulus = $urandom;
    end else if (kind == 0) begin
      bound   = $urandom;
      modulus = '0;
    end else if (kind == 1) begin
      bound   = $urandom | 32'h0400_0000;
      modulus = $urandom_range(1, 4);
    end else begin
      bound   = $urandom_range(0, 5000);
      modulus = $urandom_range(1, 500);
      if (kind < 6) begin
        modulus = {modulus[nfps_pkg::FIELD_W-1:1], 1'b0} + nfps_pkg::FIELD_W'(2);
      end
    end
    send_item(bound, modulus);
  endtask

  initial begin
    logic [nfps_pkg::LIMIT_W-1:0] limit;
    int                           count;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed requests under the reset limit: the smallest primes, a
    // composite first candidate, a Fermat prime, zero modulus at both ends
    // of the bound, and a bound so high that no multiplier is in range.
    send_item(32'd0, 32'd1);
    send_item(32'd2, 32'd1);
    send_item(32'd0, 32'd2);
    send_item(32'd100, 32'd64);
    send_item(32'd1000, 32'd12);
    send_item(32'd65536, 32'd256);
    send_item(32'd0, 32'd0);
    send_item(32'hFFFF_FFFF, 32'd0);
    send_item(32'hFFFF_FFFF, 32'd1);

    // A limit of two: an exhausted search on an even candidate, a quick
    // find, and a start multiplier that equals the limit.
    write_limit(20'd2);
    send_item(32'd0, 32'd7);
    send_item(32'd0, 32'd4);
    send_item(32'd13, 32'd7);

    // A limit of one leaves nothing to test, so the widest fields go here.
    write_limit(20'd1);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'd0, 32'hFFFF_FFFF);
    send_item(32'd0, 32'h8000_0000);
    send_item(32'd0, 32'd1);

    // A zero limit rules out every multiplier.
    write_limit(20'd0);
    send_item(32'd0, 32'd1);
    send_item(32'd0, 32'd0);

    // The largest limit, with the last few multipliers below it.
    write_limit(LIMIT_MAX);
    send_item(32'h000F_FFFE, 32'd1);
    send_item(32'd1048570, 32'd1);

    // Random requests in phases, each under a fresh limit.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      unique case (ph)
        0:       limit = nfps_pkg::LIMIT_W'($urandom_range(2, 8));
        1:       limit = nfps_pkg::LIMIT_W'($urandom_range(9, 20'hFFFFF));
        2:       limit = 20'd1;
        3:       limit = LIMIT_MAX;
        4:       limit = nfps_pkg::LIMIT_RESET;
        5:       limit = 20'd0;
        default: limit = nfps_pkg::LIMIT_W'($urandom_range(1, 3));
      endcase
      write_limit(limit);
      count = $urandom_range(10, 16);
      for (int i = 0; i < count; i++) send_random(limit);
    end

    lower_start();
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d search requests under %0d search-limit settings.",
             items_sent, limit_writes + 1);
    $display("%0d of the results reported a prime, the rest reported none.",
             primes_found);
    if (errors == 0 && pending == 0) begin
      $display("ntt_friendly_prime_search: match");
    end else begin
      $display("ntt_friendly_prime_search: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/nfps_pkg.sv
hw/rtl/nfps_div.sv
hw/rtl/ntt_friendly_prime_search.sv
sim/nfps_checker.sv
sim/tb_top.sv
